// ----- hdl/sequential_byte_list_assert.svh -----
// Assertion macros for the RTL datapath; empty when synthesising.
`ifndef SEQUENTIAL_BYTE_LIST_ASSERT_SVH
`define SEQUENTIAL_BYTE_LIST_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SBL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define SBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBL_ASSERT_SAME(label, ante, cons, msg)
`define SBL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/sbl_pkg.sv -----
package sbl_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 4;
    localparam int DATA_W = 8;
    localparam int STAT_W = 3;
    localparam int FILL_W = 5;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MODIFY  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ_CAP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SWAP_CHK,
        S_SWAP_RDHI,
        S_SWAP_WRLO,
        S_SWAP_WRHI,
        S_FINISH
    } state_t;

    // RAM address source
    typedef enum logic [2:0] {
        ADR_OCC,
        ADR_POS,
        ADR_IDX,
        ADR_IDX1,
        ADR_HI
    } adr_sel_t;

    // RAM write data source
    typedef enum logic [1:0] {
        WD_VAL,
        WD_RD,
        WD_TMP
    } wd_sel_t;

    typedef struct packed {
        logic                in_ready;
        logic                occ_inc;
        logic                occ_dec;
        logic                idx_load_pos;
        logic                idx_clear;
        logic                idx_inc;
        logic                hi_load;
        logic                hi_dec;
        logic                tmp_load;
        logic                rdata_load;
        logic                status_load;
        logic [STAT_W-1:0]   status_code;
        adr_sel_t            rd_sel;
        logic                wr_en;
        adr_sel_t            wr_sel;
        wd_sel_t             wd_sel;
        logic                out_load;
    } ctl_t;

    typedef struct packed {
        logic                in_accept;
        logic [CMD_W-1:0]    cmd;
        logic                empty;
        logic                full;
        logic                pos_bad;
        logic                shift_more;
        logic                scan_more;
        logic                match;
        logic                swap_more;
        logic                out_free;
    } stat_t;

endpackage

// ----- hdl/sbl_ram.sv -----
module sbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sbl_ctrl.sv -----
module sbl_ctrl
    import sbl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.in_accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                if (stat.cmd inside {CMD_MODIFY, CMD_REMOVE, CMD_READ})
                begin
                    if (!stat.empty && !stat.pos_bad)
                    begin
                        if (stat.cmd == CMD_REMOVE)
                        begin
                            state_next = S_SHIFT_RD;
                        end
                        else if (stat.cmd == CMD_READ)
                        begin
                            state_next = S_READ_CAP;
                        end
                    end
                end
                else if (stat.cmd == CMD_SEARCH && !stat.empty)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (stat.cmd == CMD_REVERSE && !stat.empty)
                begin
                    state_next = S_SWAP_CHK;
                end
            end
            S_READ_CAP:  state_next = S_FINISH;
            S_SHIFT_RD:  state_next = stat.shift_more ? S_SHIFT_WR : S_FINISH;
            S_SHIFT_WR:  state_next = S_SHIFT_RD;
            S_SCAN_RD:   state_next = stat.scan_more ? S_SCAN_CMP : S_FINISH;
            S_SCAN_CMP:  state_next = stat.match ? S_FINISH : S_SCAN_RD;
            S_SWAP_CHK:  state_next = stat.swap_more ? S_SWAP_RDHI : S_FINISH;
            S_SWAP_RDHI: state_next = S_SWAP_WRLO;
            S_SWAP_WRLO: state_next = S_SWAP_WRHI;
            S_SWAP_WRHI: state_next = S_SWAP_CHK;
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        ctl        = '0;
        ctl.rd_sel = ADR_IDX;
        ctl.wr_sel = ADR_IDX;
        ctl.wd_sel = WD_RD;
        case (state_reg)
            S_IDLE:
            begin
                ctl.in_ready = 1'b1;
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            ctl.status_load = 1'b1;
                            ctl.status_code = STAT_FULL;
                        end
                        else
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.wr_sel  = ADR_OCC;
                            ctl.wd_sel  = WD_VAL;
                            ctl.occ_inc = 1'b1;
                        end
                    end
                    CMD_MODIFY, CMD_REMOVE, CMD_READ:
                    begin
                        if (stat.empty)
                        begin
                            ctl.status_load = 1'b1;
                            ctl.status_code = STAT_EMPTY;
                        end
                        else if (stat.pos_bad)
                        begin
                            ctl.status_load = 1'b1;
                            ctl.status_code = STAT_BADPOS;
                        end
                        else if (stat.cmd == CMD_MODIFY)
                        begin
                            ctl.wr_en  = 1'b1;
                            ctl.wr_sel = ADR_POS;
                            ctl.wd_sel = WD_VAL;
                        end
                        else if (stat.cmd == CMD_REMOVE)
                        begin
                            ctl.idx_load_pos = 1'b1;
                        end
                        else
                        begin
                            ctl.rd_sel = ADR_POS;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        ctl.status_load = 1'b1;
                        ctl.status_code = stat.empty ? STAT_EMPTY : STAT_NOTFOUND;
                        ctl.idx_clear   = 1'b1;
                    end
                    CMD_REVERSE:
                    begin
                        if (stat.empty)
                        begin
                            ctl.status_load = 1'b1;
                            ctl.status_code = STAT_EMPTY;
                        end
                        else
                        begin
                            ctl.idx_clear = 1'b1;
                            ctl.hi_load   = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_READ_CAP:
            begin
                ctl.rdata_load = 1'b1;
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_more)
                begin
                    ctl.rd_sel = ADR_IDX1;
                end
                else
                begin
                    ctl.occ_dec = 1'b1;
                end
            end
            S_SHIFT_WR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.idx_inc = 1'b1;
            end
            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    ctl.status_load = 1'b1;
                    ctl.status_code = STAT_OK;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                end
            end
            S_SWAP_RDHI:
            begin
                ctl.tmp_load = 1'b1;
                ctl.rd_sel   = ADR_HI;
            end
            S_SWAP_WRLO:
            begin
                ctl.wr_en = 1'b1;
            end
            S_SWAP_WRHI:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_sel  = ADR_HI;
                ctl.wd_sel  = WD_TMP;
                ctl.idx_inc = 1'b1;
                ctl.hi_dec  = 1'b1;
            end
            S_FINISH:
            begin
                ctl.out_load = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hdl/sbl_datapath.sv -----
`include "sequential_byte_list_assert.svh"

module sbl_datapath
    import sbl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_t                   ctl,
    output stat_t                  stat,
    input  logic                   s_tvalid,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] hi_reg;
    logic [DATA_W-1:0] tmp_reg;
    logic [STAT_W-1:0] status_reg;
    logic [DATA_W-1:0] rdata_reg;

    logic [STAT_W-1:0] out_status_reg;
    logic [DATA_W-1:0] out_rdata_reg;
    logic [FILL_W-1:0] out_fill_reg;
    logic              out_valid_reg;

    logic              in_accept;
    logic [CNT_W-1:0]  idx_plus1;
    logic [CNT_W-1:0]  occ_minus1;
    logic [ADDR_W-1:0] pos_addr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    assign in_accept  = s_tvalid & ctl.in_ready;
    assign idx_plus1  = idx_reg + 1'b1;
    assign occ_minus1 = occ_reg - 1'b1;
    assign pos_addr   = ADDR_W'(pos_reg);

    always_comb
    begin
        case (ctl.rd_sel)
            ADR_OCC:  ram_raddr = occ_reg[ADDR_W-1:0];
            ADR_POS:  ram_raddr = pos_addr;
            ADR_IDX:  ram_raddr = idx_reg[ADDR_W-1:0];
            ADR_IDX1: ram_raddr = idx_plus1[ADDR_W-1:0];
            ADR_HI:   ram_raddr = hi_reg;
            default:  ram_raddr = idx_reg[ADDR_W-1:0];
        endcase
        case (ctl.wr_sel)
            ADR_OCC:  ram_waddr = occ_reg[ADDR_W-1:0];
            ADR_POS:  ram_waddr = pos_addr;
            ADR_IDX:  ram_waddr = idx_reg[ADDR_W-1:0];
            ADR_IDX1: ram_waddr = idx_plus1[ADDR_W-1:0];
            ADR_HI:   ram_waddr = hi_reg;
            default:  ram_waddr = idx_reg[ADDR_W-1:0];
        endcase
        case (ctl.wd_sel)
            WD_VAL:  ram_wdata = val_reg;
            WD_RD:   ram_wdata = ram_rdata;
            WD_TMP:  ram_wdata = tmp_reg;
            default: ram_wdata = ram_rdata;
        endcase
    end

    sbl_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_slots (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // item and working registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= s_tdata[CMD_W-1:0];
            pos_reg <= s_tdata[CMD_W+POS_W-1:CMD_W];
            val_reg <= s_tdata[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W];
        end

        if (ctl.idx_load_pos)
        begin
            idx_reg <= CNT_W'(pos_reg);
        end
        else if (ctl.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_reg <= idx_plus1;
        end

        if (ctl.hi_load)
        begin
            hi_reg <= occ_minus1[ADDR_W-1:0];
        end
        else if (ctl.hi_dec)
        begin
            hi_reg <= hi_reg - 1'b1;
        end

        if (ctl.tmp_load)
        begin
            tmp_reg <= ram_rdata;
        end

        if (in_accept)
        begin
            status_reg <= STAT_OK;
            rdata_reg  <= '0;
        end
        else
        begin
            if (ctl.status_load)
            begin
                status_reg <= ctl.status_code;
            end
            if (ctl.rdata_load)
            begin
                rdata_reg <= ram_rdata;
            end
        end

        if (ctl.out_load)
        begin
            out_status_reg <= status_reg;
            out_rdata_reg  <= rdata_reg;
            out_fill_reg   <= FILL_W'(occ_reg);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.occ_inc)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            else if (ctl.occ_dec)
            begin
                occ_reg <= occ_minus1;
            end

            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.in_accept  = in_accept;
        stat.cmd        = cmd_reg;
        stat.empty      = (occ_reg == '0);
        stat.full       = (occ_reg == CNT_W'(CAPACITY));
        stat.pos_bad    = (CMP_W'(pos_reg) >= CMP_W'(occ_reg));
        stat.shift_more = (idx_plus1 < occ_reg);
        stat.scan_more  = (idx_reg < occ_reg);
        stat.match      = (ram_rdata == val_reg);
        stat.swap_more  = (idx_reg < CNT_W'(hi_reg));
        stat.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_fill_reg, out_rdata_reg, out_status_reg};

    `SBL_ASSERT_SAME(a_occ_bound, 1'b1, occ_reg <= CNT_W'(CAPACITY), "fill count beyond capacity")
    `SBL_ASSERT_SAME(a_inc_not_full, ctl.occ_inc, !stat.full && !ctl.occ_dec, "append on full list")
    `SBL_ASSERT_SAME(a_dec_not_empty, ctl.occ_dec, !stat.empty, "remove on empty list")
    `SBL_ASSERT_SAME(a_out_free, ctl.out_load, stat.out_free, "result overwrites pending beat")
    `SBL_ASSERT_NEXT(a_accept_idle, in_accept, !ctl.in_ready && !out_valid_reg || !ctl.in_ready,
        "second beat taken while busy")

endmodule

// ----- hdl/sequential_byte_list.sv -----
// Append, modify, bad/empty cases and unused codes go from decode straight to the result;
// read first captures the RAM word; remove shifts the tail down; search scans from the
// head; reverse swaps pairs from both ends inward. A command is taken only while idle, so
// a new one waits until the previous one is through. A new beat is taken while the
// previous result waits in the output register. Reset (rst_n low, asynchronous) empties
// the list and drops any pending result; element RAM contents are left as they were.
module sequential_byte_list
    import sbl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // command beat
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // command[2:0], position[6:3], value[14:7], 0
    // result beat
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // status[2:0], read_data[10:3], fill_count[15:11]
);

    ctl_t  ctl;
    stat_t stat;

    // state machine: decodes the command and sequences the RAM walk
    sbl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // element store, fill count, walk indices and the output register
    sbl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ready only while the sequencer sits idle
    assign s_tready = ctl.in_ready;

endmodule
